FILE: hdl/dvr_pkg.sv
// shared types, constants and helpers for the distance-vector route update block
`default_nettype none
package dvr_pkg;

   localparam int NODES    = 16;
   localparam int NODE_W   = $clog2(NODES);
   localparam int CNT_W    = NODE_W + 1;
   localparam int ADDR_W   = 2 * NODE_W;
   localparam int COST_W   = 16;
   localparam logic [COST_W-1:0] COST_INF = '1;

   // input actions
   localparam logic ACT_LINK   = 1'b0;
   localparam logic ACT_VECTOR = 1'b1;

   // result kinds
   localparam logic KIND_ROUTE  = 1'b0;
   localparam logic KIND_ADVERT = 1'b1;

   // register indexes
   localparam logic CSR_SELF  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DSEL,
      ST_SCAN,
      ST_FIN,
      ST_ADV,
      ST_ADVW
   } state_type;

   // table access from the sequencer
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [COST_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } tbl_req_type;

   // one result word toward the output register
   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [NODE_W-1:0] dest;
      logic [NODE_W-1:0] hop;
      logic [COST_W-1:0] cost;
      logic              last;
   } emit_type;

   // saturating cost addition, infinity absorbs
   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (a == COST_INF || b == COST_INF || s[COST_W])
         return COST_INF;
      return s[COST_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/dvr_table.sv
// distance table memory with valid bits standing in for the reset contents
`default_nettype none
module dvr_table
   import dvr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tbl_req_type       req,
   output      logic [COST_W-1:0] rdata
);

   localparam int DEPTH = NODES * NODES;

   logic [COST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [COST_W-1:0] data_ff;
   logic              vld_ff;
   logic              diag_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         data_ff <= mem[req.raddr];
      end
   end

   // written marks and their read side
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
         diag_ff  <= 1'b0;
      end else begin
         if (req.we) begin
            valid_ff[req.waddr] <= 1'b1;
         end
         if (req.re) begin
            vld_ff  <= valid_ff[req.raddr];
            diag_ff <= req.raddr[ADDR_W-1 -: NODE_W] == req.raddr[NODE_W-1:0];
         end
      end
   end

   // unwritten entries read as diagonal zero, else infinity
   always_comb begin
      if (vld_ff)
         rdata = data_ff;
      else if (diag_ff)
         rdata = '0;
      else
         rdata = COST_INF;
   end

endmodule
`default_nettype wire

FILE: hdl/dvr_ctrl.sv
// recompute sequencer, link cost registers and table access control
`default_nettype none
module dvr_ctrl
   import dvr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_action,
   input  wire logic [NODE_W-1:0] req_peer,
   input  wire logic [NODE_W-1:0] req_dest_index,
   input  wire logic [COST_W-1:0] req_cost,
   input  wire logic              req_last_entry,
   input  wire logic [CNT_W-1:0]  node_n,
   input  wire logic [NODE_W-1:0] me,
   input  wire logic              out_free,
   input  wire logic [COST_W-1:0] rdata,
   output      tbl_req_type       tbl,
   output      emit_type          emit
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  d_ff, d_in;
   logic [CNT_W-1:0]  ic_ff, ic_in;
   logic [CNT_W-1:0]  a_ff, a_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [NODE_W-1:0] hop_ff, hop_in;
   logic              adv_ff, adv_in;
   logic              chg_ff, chg_in;
   logic              tag_vld_ff, tag_vld_in;
   logic              tag_own_ff, tag_own_in;
   logic [NODE_W-1:0] tag_i_ff, tag_i_in;
   logic [COST_W-1:0] link_ff [NODES];

   logic              accept;
   logic              trigger;
   logic [CNT_W-1:0]  last_d;
   logic [CNT_W-1:0]  me_w;
   logic [COST_W-1:0] lk;
   logic [COST_W-1:0] cand;
   logic              take;
   logic              own_chg;

   assign accept  = req_valid && req_ready;
   assign trigger = (req_action == ACT_LINK) || req_last_entry;
   assign me_w    = {1'b0, me};
   assign last_d  = (node_n - 1'b1 == me_w) ? node_n - 5'd2 : node_n - 1'b1;

   // candidate from the neighbor row word now returning
   assign lk      = link_ff[tag_i_ff];
   assign cand    = sat_add(lk, rdata);
   assign take    = tag_vld_ff && !tag_own_ff && (tag_i_ff != me) &&
                    (lk != COST_INF) && (cand < best_ff);
   assign own_chg = rdata != best_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && trigger)
               state_in = ST_DSEL;
         end
         ST_DSEL: begin
            if (d_ff >= node_n)
               state_in = (adv_ff || chg_ff) ? ST_ADV : ST_IDLE;
            else if (d_ff != me_w)
               state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (ic_ff == node_n)
               state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free)
               state_in = ST_DSEL;
         end
         ST_ADV: begin
            state_in = ST_ADVW;
         end
         ST_ADVW: begin
            if (out_free)
               state_in = (a_ff == node_n - 1'b1) ? ST_IDLE : ST_ADV;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath next values
   always_comb begin
      req_ready  = 1'b0;
      tbl        = '0;
      emit       = '0;
      d_in       = d_ff;
      ic_in      = ic_ff;
      a_in       = a_ff;
      best_in    = take ? cand : best_ff;
      hop_in     = take ? tag_i_ff : hop_ff;
      adv_in     = adv_ff;
      chg_in     = chg_ff;
      tag_vld_in = 1'b0;
      tag_own_in = tag_own_ff;
      tag_i_in   = tag_i_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_action == ACT_VECTOR && req_peer != me) begin
                  tbl.we    = 1'b1;
                  tbl.waddr = {req_peer, req_dest_index};
                  tbl.wdata = req_cost;
               end
               d_in   = '0;
               adv_in = req_action == ACT_LINK;
               chg_in = 1'b0;
            end
         end
         ST_DSEL: begin
            if (d_ff >= node_n) begin
               a_in = '0;
            end else if (d_ff == me_w) begin
               d_in = d_ff + 1'b1;
            end else begin
               best_in = COST_INF;
               hop_in  = me;
               ic_in   = '0;
            end
         end
         ST_SCAN: begin
            tbl.re     = 1'b1;
            tbl.raddr  = (ic_ff == node_n) ? {me, d_ff[NODE_W-1:0]}
                                           : {ic_ff[NODE_W-1:0], d_ff[NODE_W-1:0]};
            tag_vld_in = 1'b1;
            tag_own_in = ic_ff == node_n;
            tag_i_in   = ic_ff[NODE_W-1:0];
            ic_in      = ic_ff + 1'b1;
         end
         ST_FIN: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_ROUTE;
            emit.dest  = d_ff[NODE_W-1:0];
            emit.hop   = hop_ff;
            emit.cost  = best_ff;
            emit.last  = (d_ff == last_d) && !(adv_ff || chg_ff || own_chg);
            if (out_free) begin
               tbl.we    = 1'b1;
               tbl.waddr = {me, d_ff[NODE_W-1:0]};
               tbl.wdata = best_ff;
               chg_in    = chg_ff || own_chg;
               d_in      = d_ff + 1'b1;
            end
         end
         ST_ADV: begin
            tbl.re    = 1'b1;
            tbl.raddr = {me, a_ff[NODE_W-1:0]};
         end
         ST_ADVW: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_ADVERT;
            emit.dest  = a_ff[NODE_W-1:0];
            emit.hop   = me;
            emit.cost  = rdata;
            emit.last  = a_ff == node_n - 1'b1;
            if (out_free)
               a_in = a_ff + 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tag_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= tag_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      d_ff       <= d_in;
      ic_ff      <= ic_in;
      a_ff       <= a_in;
      best_ff    <= best_in;
      hop_ff     <= hop_in;
      adv_ff     <= adv_in;
      chg_ff     <= chg_in;
      tag_own_ff <= tag_own_in;
      tag_i_ff   <= tag_i_in;
   end

   // link costs, infinity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NODES; k++)
            link_ff[k] <= COST_INF;
      end else if (accept && req_action == ACT_LINK) begin
         link_ff[req_peer] <= req_cost;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/distance_vector_route_update.sv
// top level: config registers, output register, table and sequencer
//
//  channel  | direction | handshake          | word
//  req_     | in        | req_valid/ready    | action, peer, dest_index, cost, last_entry
//  rsp_     | out       | rsp_valid/ready    | kind, dest, next_hop, route_cost, last
//  csr_     | in        | csr_write_enable   | csr_index, csr_write_data
//
// a vector entry without last mark starts no recompute. a recompute over n nodes
// scans each destination with one table read per node row plus the own entry,
// through the single read port, then, if a link or route changed, reads and emits each advertised word.
// reset is synchronous; unwritten table entries read as their reset values.
// a stalled result holds the sequencer in place; inputs are taken only when idle.
`default_nettype none
module distance_vector_route_update
   import dvr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_action,
   input  wire logic [NODE_W-1:0] req_peer,
   input  wire logic [NODE_W-1:0] req_dest_index,
   input  wire logic [COST_W-1:0] req_cost,
   input  wire logic              req_last_entry,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic              rsp_kind,
   output      logic [NODE_W-1:0] rsp_dest,
   output      logic [NODE_W-1:0] rsp_next_hop,
   output      logic [COST_W-1:0] rsp_route_cost,
   output      logic              rsp_last,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [CNT_W-1:0]  csr_write_data
);

   logic [NODE_W-1:0] self_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  node_n;
   logic              rsp_valid_ff, rsp_valid_in;
   emit_type          rsp_ff;
   emit_type          emit;
   tbl_req_type       tbl;
   logic [COST_W-1:0] rdata;
   logic              out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff  <= '0;
         count_ff <= CNT_W'(NODES);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SELF:  self_ff  <= csr_write_data[NODE_W-1:0];
            CSR_COUNT: count_ff <= csr_write_data;
            default:   self_ff  <= self_ff;
         endcase
      end
   end

   // clamp node count into one .. NODES
   always_comb begin
      if (count_ff == '0)
         node_n = CNT_W'(1);
      else if (count_ff > CNT_W'(NODES))
         node_n = CNT_W'(NODES);
      else
         node_n = count_ff;
   end

   dvr_table u_table (
      .clock (clock),
      .reset (reset),
      .req   (tbl),
      .rdata (rdata)
   );

   dvr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_peer       (req_peer),
      .req_dest_index (req_dest_index),
      .req_cost       (req_cost),
      .req_last_entry (req_last_entry),
      .node_n         (node_n),
      .me             (self_ff),
      .out_free       (out_free),
      .rdata          (rdata),
      .tbl            (tbl),
      .emit           (emit)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (emit.valid && out_free) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (emit.valid && out_free)
         rsp_ff <= emit;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_dest       = rsp_ff.dest;
   assign rsp_next_hop   = rsp_ff.hop;
   assign rsp_route_cost = rsp_ff.cost;
   assign rsp_last       = rsp_ff.last;

   // the sequencer never produces a word while taking input
   a_emit_not_idle: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> !req_ready)
      else $error("result word produced while input open");

   // a link change always starts a recompute
   a_link_recomputes: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_LINK |=> !req_ready)
      else $error("link change did not start recompute");

   // outside idle a table write only comes with a route word being taken
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      tbl.we && !req_ready |-> emit.valid && out_free && emit.kind == KIND_ROUTE)
      else $error("unexpected table write");

endmodule
`default_nettype wire
